FILE: sv/cpt_pkg.sv
// shared constants and elaboration-time helpers for the clarke/park transform
// depends on nothing; imported by the top level, the front end, the back end and the sine rom

package cpt_pkg;

  // queue depths between the parts of the block
  localparam int CMD_FIFO_DEPTH = 4;
  localparam int RES_FIFO_DEPTH = 8;

  // q15 coefficients
  localparam logic signed [15:0] INV_SQRT3_Q15  = 16'sd18919;
  localparam logic signed [15:0] SQRT3_HALF_Q15 = 16'sd28378;
  localparam int                 Q15_HALF       = 16384;
  localparam int                 Q15_SHIFT      = 15;
  localparam int                 NEG_HALF_SHIFT = 14;

  // sine amplitude and pi/2 in q60 used to build the quarter-wave rom
  localparam longint unsigned SINE_AMPL   = 64'd32767;
  localparam longint unsigned HALF_PI_Q60 = 64'h1921FB54442D1847;
  localparam int              TRIG_W      = 16;
  localparam int              MAG_W       = 15;

  // (a*b) >> 60 for operands below 2^62
  function automatic longint unsigned mul_q60(input longint unsigned a,
                                              input longint unsigned b);
    longint unsigned ah, al, bh, bl, mid;
    ah  = a >> 32;
    al  = a & 64'hFFFF_FFFF;
    bh  = b >> 32;
    bl  = b & 64'hFFFF_FFFF;
    mid = ah * bl + al * bh + ((al * bl) >> 32);
    return ((ah * bh) << 4) + (mid >> 28);
  endfunction

  // restoring shift-subtract quotient of two 64-bit values
  function automatic longint unsigned div_u64(input longint unsigned num,
                                              input longint unsigned den);
    longint unsigned quo, rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // taylor series sine of a q60 angle in [0, pi/2]
  function automatic longint unsigned sin_q60(input longint unsigned x);
    longint unsigned x2, term, sum, dv;
    x2   = mul_q60(x, x);
    term = x;
    sum  = x;
    for (int n = 1; n < 40; n++) begin
      if (term != 64'd0) begin
        dv   = longint'(2 * n) * longint'(2 * n + 1);
        term = div_u64(mul_q60(term, x2), dv);
        if (n[0] == 1'b1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
    end
    return sum;
  endfunction

  // one rom entry: round(32767 * sin(pi/2 * k / 2^tb))
  function automatic logic [MAG_W-1:0] sine_value(input int unsigned k,
                                                  input int unsigned tb);
    longint unsigned step, s, v;
    step = HALF_PI_Q60 >> tb;
    s    = sin_q60(step * longint'(k));
    v    = ((s >> 20) * SINE_AMPL + (64'd1 << 39)) >> 40;
    if (v > SINE_AMPL) begin
      v = SINE_AMPL;
    end
    return v[MAG_W-1:0];
  endfunction

endpackage

FILE: sv/clarke_park_transform.sv
// top level of the clarke/park transform pair for field-oriented control
// depends on cpt_pkg, cpt_fifo, cpt_front, cpt_back (and cpt_sine_rom below it)
//
//   channel   direction  handshake     transaction moved
//   input     in         push / full   mode, angle, in_first, in_second
//   result    out        empty / pop   out_first..out_beta, saturated
//
// sustained rate is one transaction per cycle while the result side pops: the
// back end is a fully pipelined five-stage datapath with one dual-read sine rom
// lookup per item; each item passes the front-end command register first.
// reset (rst_ni low) empties both queues and the pipeline; the rom is constant.
// a stalled result side fills the result queue and then the command queue,
// after which full rises; no transaction is dropped.

module clarke_park_transform #(
  parameter int SAMPLE_WIDTH    = 16,
  parameter int ANGLE_WIDTH     = 16,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic                           mode_i,
  input  logic [ANGLE_WIDTH-1:0]         angle_i,
  input  logic signed [SAMPLE_WIDTH-1:0] in_first_i,
  input  logic signed [SAMPLE_WIDTH-1:0] in_second_i,
  output logic                           empty,
  input  logic                           pop,
  output logic signed [SAMPLE_WIDTH-1:0] out_first_o,
  output logic signed [SAMPLE_WIDTH-1:0] out_second_o,
  output logic signed [SAMPLE_WIDTH-1:0] out_third_o,
  output logic signed [SAMPLE_WIDTH-1:0] out_alpha_o,
  output logic signed [SAMPLE_WIDTH-1:0] out_beta_o,
  output logic                           saturated_o
);

  import cpt_pkg::*;

  localparam int W     = SAMPLE_WIDTH;
  localparam int TB    = SINE_TABLE_BITS;
  localparam int CMD_W = 3 * W + TB + 5;
  localparam int RES_W = 5 * W + 1;

  logic                              cmd_valid, cmd_full, cmd_empty, cmd_pop;
  logic [CMD_W-1:0]                  cmd_wdata, cmd_rdata;
  logic [$clog2(CMD_FIFO_DEPTH):0]   cmd_count;
  logic                              res_wr, res_full;
  logic [RES_W-1:0]                  res_wdata, res_rdata;
  logic [$clog2(RES_FIFO_DEPTH):0]   res_count;

  // input side
  cpt_front #(
    .W (W),
    .AW(ANGLE_WIDTH),
    .TB(TB)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .mode_i     (mode_i),
    .angle_i    (angle_i),
    .in_first_i (in_first_i),
    .in_second_i(in_second_i),
    .cmd_valid_o(cmd_valid),
    .cmd_data_o (cmd_wdata),
    .cmd_full_i (cmd_full)
  );

  // decoupling queue between front and back
  cpt_fifo #(
    .DATA_W(CMD_W),
    .DEPTH (CMD_FIFO_DEPTH)
  ) u_cmd_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(cmd_valid),
    .wr_data_i (cmd_wdata),
    .full_o    (cmd_full),
    .rd_pop_i  (cmd_pop),
    .rd_data_o (cmd_rdata),
    .empty_o   (cmd_empty),
    .count_o   (cmd_count)
  );

  // transform pipeline
  cpt_back #(
    .W (W),
    .TB(TB),
    .RD(RES_FIFO_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_data_i (cmd_rdata),
    .cmd_empty_i(cmd_empty),
    .cmd_pop_o  (cmd_pop),
    .res_count_i(res_count),
    .res_wr_o   (res_wr),
    .res_data_o (res_wdata)
  );

  // result queue
  cpt_fifo #(
    .DATA_W(RES_W),
    .DEPTH (RES_FIFO_DEPTH)
  ) u_res_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(res_wr),
    .wr_data_i (res_wdata),
    .full_o    (res_full),
    .rd_pop_i  (pop),
    .rd_data_o (res_rdata),
    .empty_o   (empty),
    .count_o   (res_count)
  );

  assign {out_first_o, out_second_o, out_third_o, out_alpha_o, out_beta_o,
          saturated_o} = res_rdata;

`ifndef SYNTHESIS
  // the credit scheme must keep the result queue from overflowing
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(res_wr && res_full))
    else $error("result written into a full queue");

  // a command held by the front end stays put while the queue is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid && cmd_full) |=> (cmd_valid && $stable(cmd_wdata)))
    else $error("front end lost a command while the queue was full");

  // the back end only pops a command that is there
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> (cmd_count != '0))
    else $error("command popped from an empty queue");
`endif

endmodule

FILE: sv/cpt_fifo.sv
// small register-based fifo with occupancy count
// depends on nothing outside this file

module cpt_fifo #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       wr_valid_i,
  input  logic [DATA_W-1:0]          wr_data_i,
  output logic                       full_o,
  input  logic                       rd_pop_i,
  output logic [DATA_W-1:0]          rd_data_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH):0]     count_o
);

  localparam int PW = $clog2(DEPTH);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PW:0]       wr_ptr_q, wr_ptr_d;
  logic [PW:0]       rd_ptr_q, rd_ptr_d;
  logic              wr_en, rd_en;

  // occupancy and flags
  assign count_o   = wr_ptr_q - rd_ptr_q;
  assign full_o    = (count_o == (PW + 1)'(DEPTH));
  assign empty_o   = (wr_ptr_q == rd_ptr_q);
  assign wr_en     = wr_valid_i & ~full_o;
  assign rd_en     = rd_pop_i & ~empty_o;
  assign rd_data_o = mem_q[rd_ptr_q[PW-1:0]];

  assign wr_ptr_d = wr_en ? wr_ptr_q + (PW + 1)'(1) : wr_ptr_q;
  assign rd_ptr_d = rd_en ? rd_ptr_q + (PW + 1)'(1) : rd_ptr_q;

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q[PW-1:0]] <= wr_data_i;
    end
  end

endmodule

FILE: sv/cpt_sine_rom.sv
// quarter-wave sine rom with two registered read ports
// depends on cpt_pkg for the entry generator

module cpt_sine_rom #(
  parameter int TB = 10
) (
  input  logic                          clk_i,
  input  logic [TB:0]                   sin_addr_i,
  input  logic [TB:0]                   cos_addr_i,
  output logic [cpt_pkg::MAG_W-1:0]     sin_mag_o,
  output logic [cpt_pkg::MAG_W-1:0]     cos_mag_o
);

  import cpt_pkg::*;

  localparam int DEPTH = (1 << TB) + 1;

  typedef logic [MAG_W-1:0] rom_t [DEPTH];

  function automatic rom_t build_rom();
    rom_t r;
    for (int k = 0; k < DEPTH; k++) begin
      r[k] = sine_value(k, TB);
    end
    return r;
  endfunction

  localparam rom_t ROM = build_rom();

  // two synchronous reads per cycle
  always_ff @(posedge clk_i) begin
    sin_mag_o <= ROM[sin_addr_i];
    cos_mag_o <= ROM[cos_addr_i];
  end

endmodule

FILE: sv/cpt_front.sv
// front end: takes transactions, derives the full-turn table index and the
// clarke pre-sum, and hands a packed command to the command queue; uses cpt_pkg

module cpt_front #(
  parameter int W  = 16,
  parameter int AW = 16,
  parameter int TB = 10
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  output logic                       full_o,
  input  logic                       mode_i,
  input  logic [AW-1:0]              angle_i,
  input  logic signed [W-1:0]        in_first_i,
  input  logic signed [W-1:0]        in_second_i,
  output logic                       cmd_valid_o,
  output logic [3*W+TB+4:0]          cmd_data_o,
  input  logic                       cmd_full_i
);

  import cpt_pkg::*;

  localparam int FW = TB + 2;
  localparam int CW = 3 * W + TB + 5;

  logic                 valid_q, valid_d;
  logic [CW-1:0]        cmd_q;
  logic [FW-1:0]        f_idx;
  logic signed [W+1:0]  csum;
  logic                 accept;

  // full-turn index: top bits of the angle, zero padded when narrower
  if (AW >= FW) begin : g_angle_cut
    assign f_idx = angle_i[AW-1 -: FW];
  end else begin : g_angle_pad
    assign f_idx = {angle_i, {(FW - AW){1'b0}}};
  end

  // a + 2b for the reduced clarke transform
  assign csum = (W + 2)'(in_first_i) + ((W + 2)'(in_second_i) <<< 1);

  // a held command blocks only while the queue is full
  assign full_o      = valid_q & cmd_full_i;
  assign accept      = push_i & ~full_o;
  assign cmd_valid_o = valid_q;
  assign cmd_data_o  = cmd_q;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (!cmd_full_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= {mode_i, f_idx, in_first_i, in_second_i, csum};
    end
  end

endmodule

FILE: sv/cpt_back.sv
// back end: five-stage pipeline for sine/cosine lookup, clarke, park and their
// inverses, with credit flow into the result queue; uses cpt_pkg, cpt_sine_rom

module cpt_back #(
  parameter int W  = 16,
  parameter int TB = 10,
  parameter int RD = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [3*W+TB+4:0]          cmd_data_i,
  input  logic                       cmd_empty_i,
  output logic                       cmd_pop_o,
  input  logic [$clog2(RD):0]        res_count_i,
  output logic                       res_wr_o,
  output logic [5*W:0]               res_data_o
);

  import cpt_pkg::*;

  localparam int FW   = TB + 2;
  localparam int RW   = W + 19;
  localparam int PW1  = W + 18;
  localparam int PW   = W + 16;
  localparam int SW   = W + 17;
  localparam int CNTW = $clog2(RD) + 1;
  localparam int IFW  = 3;
  localparam int OCW  = CNTW + IFW;

  localparam logic signed [RW-1:0] RND_HALF = RW'(Q15_HALF);
  localparam logic signed [RW-1:0] SAT_MAX  = RW'((64'sd1 <<< (W - 1)) - 64'sd1);
  localparam logic signed [RW-1:0] SAT_MIN  = RW'(-(64'sd1 <<< (W - 1)));
  localparam logic [TB:0]          QTR      = (TB + 1)'(1) << TB;

  // round half up by floor shift, then clip; msb of the result is the clip flag
  function automatic logic [W:0] rnd_sat(input logic signed [RW-1:0] v);
    logic signed [RW-1:0] t;
    logic [W:0]           r;
    t = (v + RND_HALF) >>> Q15_SHIFT;
    if (t > SAT_MAX) begin
      r = {1'b1, SAT_MAX[W-1:0]};
    end else if (t < SAT_MIN) begin
      r = {1'b1, SAT_MIN[W-1:0]};
    end else begin
      r = {1'b0, t[W-1:0]};
    end
    return r;
  endfunction

  // command fields
  logic                 c_mode;
  logic [FW-1:0]        c_f;
  logic signed [W-1:0]  c_x1, c_x2;
  logic signed [W+1:0]  c_csum;
  logic [1:0]           quad_s, quad_c;
  logic [TB-1:0]        phase;
  logic [TB:0]          sin_addr, cos_addr;
  logic                 pop;

  assign {c_mode, c_f, c_x1, c_x2, c_csum} = cmd_data_i;
  assign quad_s = c_f[FW-1:TB];
  assign quad_c = quad_s + 2'd1;
  assign phase  = c_f[TB-1:0];

  // quarter-wave mirroring for sine and cosine
  assign sin_addr = quad_s[0] ? QTR - {1'b0, phase} : {1'b0, phase};
  assign cos_addr = quad_c[0] ? QTR - {1'b0, phase} : {1'b0, phase};

  // stage valids
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic [IFW-1:0] inflight;
  logic [OCW-1:0] occupancy;

  // credit: items in flight plus queued results never exceed the result queue
  assign inflight  = IFW'(v1_q) + IFW'(v2_q) + IFW'(v3_q) + IFW'(v4_q) + IFW'(v5_q);
  assign occupancy = OCW'(res_count_i) + OCW'(inflight);
  assign pop       = ~cmd_empty_i & (occupancy < OCW'(RD));
  assign cmd_pop_o = pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= pop;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // stage 1: rom read and clarke product
  logic [MAG_W-1:0]      sin_mag, cos_mag;
  logic                  mode1_q, sneg1_q, cneg1_q;
  logic signed [W-1:0]   x1_1_q, x2_1_q;
  logic signed [PW1-1:0] prod1_q;

  cpt_sine_rom #(
    .TB(TB)
  ) u_rom (
    .clk_i     (clk_i),
    .sin_addr_i(sin_addr),
    .cos_addr_i(cos_addr),
    .sin_mag_o (sin_mag),
    .cos_mag_o (cos_mag)
  );

  always_ff @(posedge clk_i) begin
    mode1_q <= c_mode;
    sneg1_q <= quad_s[1];
    cneg1_q <= quad_c[1];
    x1_1_q  <= c_x1;
    x2_1_q  <= c_x2;
    prod1_q <= PW1'(c_csum) * PW1'(INV_SQRT3_Q15);
  end

  // stage 2: signed trig values, forward beta, operand selection
  logic signed [TRIG_W-1:0] s1, c1;
  logic [W:0]               beta_f;
  logic signed [TRIG_W-1:0] s2_q, c2_q;
  logic signed [W-1:0]      u2_q, w2_q;
  logic                     mode2_q, flag2_q;

  assign s1     = sneg1_q ? -TRIG_W'(sin_mag) : TRIG_W'(sin_mag);
  assign c1     = cneg1_q ? -TRIG_W'(cos_mag) : TRIG_W'(cos_mag);
  assign beta_f = rnd_sat(RW'(prod1_q));

  always_ff @(posedge clk_i) begin
    mode2_q <= mode1_q;
    s2_q    <= s1;
    c2_q    <= c1;
    u2_q    <= mode1_q ? x2_1_q : x1_1_q;
    w2_q    <= mode1_q ? x1_1_q : beta_f[W-1:0];
    flag2_q <= ~mode1_q & beta_f[W];
  end

  // stage 3: the four rotation products
  logic signed [PW-1:0] us3_q, wc3_q, uc3_q, ws3_q;
  logic signed [W-1:0]  u3_q, w3_q;
  logic                 mode3_q, flag3_q;

  always_ff @(posedge clk_i) begin
    us3_q   <= PW'(u2_q) * PW'(s2_q);
    wc3_q   <= PW'(w2_q) * PW'(c2_q);
    uc3_q   <= PW'(u2_q) * PW'(c2_q);
    ws3_q   <= PW'(w2_q) * PW'(s2_q);
    u3_q    <= u2_q;
    w3_q    <= w2_q;
    mode3_q <= mode2_q;
    flag3_q <= flag2_q;
  end

  // stage 4: rotation sums; park outputs or inverse-park alpha/beta
  logic signed [SW-1:0] psum, msum;
  logic [W:0]           p_sat, m_sat;
  logic signed [W-1:0]  alpha4_q, beta4_q, o1_4_q, o2_4_q;
  logic                 mode4_q, flag4_q;

  assign psum  = SW'(uc3_q) + SW'(ws3_q);
  assign msum  = SW'(us3_q) - SW'(wc3_q);
  assign p_sat = rnd_sat(RW'(psum));
  assign m_sat = rnd_sat(RW'(msum));

  always_ff @(posedge clk_i) begin
    mode4_q  <= mode3_q;
    flag4_q  <= flag3_q | p_sat[W] | m_sat[W];
    alpha4_q <= mode3_q ? p_sat[W-1:0] : u3_q;
    beta4_q  <= mode3_q ? m_sat[W-1:0] : w3_q;
    o1_4_q   <= mode3_q ? p_sat[W-1:0] : m_sat[W-1:0];
    o2_4_q   <= p_sat[W-1:0];
  end

  // stage 5: inverse clarke products
  logic signed [PW-1:0] na5_q, bb5_q;
  logic signed [W-1:0]  alpha5_q, beta5_q, o1_5_q, o2_5_q;
  logic                 mode5_q, flag5_q;

  always_ff @(posedge clk_i) begin
    na5_q    <= -(PW'(alpha4_q) <<< NEG_HALF_SHIFT);
    bb5_q    <= PW'(beta4_q) * PW'(SQRT3_HALF_Q15);
    alpha5_q <= alpha4_q;
    beta5_q  <= beta4_q;
    o1_5_q   <= o1_4_q;
    o2_5_q   <= o2_4_q;
    mode5_q  <= mode4_q;
    flag5_q  <= flag4_q;
  end

  // final sums and result packing
  logic signed [SW-1:0] bsum, csum5;
  logic [W:0]           b_sat, c_sat;
  logic signed [W-1:0]  r_second, r_third;
  logic                 r_flag;

  assign bsum  = SW'(na5_q) + SW'(bb5_q);
  assign csum5 = SW'(na5_q) - SW'(bb5_q);
  assign b_sat = rnd_sat(RW'(bsum));
  assign c_sat = rnd_sat(RW'(csum5));

  always_comb begin
    if (mode5_q) begin
      r_second = b_sat[W-1:0];
      r_third  = c_sat[W-1:0];
      r_flag   = flag5_q | b_sat[W] | c_sat[W];
    end else begin
      r_second = o2_5_q;
      r_third  = '0;
      r_flag   = flag5_q;
    end
  end

  assign res_wr_o   = v5_q;
  assign res_data_o = {o1_5_q, r_second, r_third, alpha5_q, beta5_q, r_flag};

endmodule
